>>> design/mfba_pkg.sv
`timescale 1ns / 1ps
package mfba_pkg;

  localparam int MAX_SYM = 64;
  localparam int NUM_TF  = 4;

  localparam int SYM_W   = $clog2(MAX_SYM);
  localparam int TF_W    = 2;
  localparam int ADDR_W  = SYM_W + TF_W;
  localparam int DEPTH   = MAX_SYM * NUM_TF;

  localparam int TS_W    = 63;
  localparam int PX_W    = 32;
  localparam int VOL_W   = 48;
  localparam int CNT_W   = 32;
  localparam int PER_W   = 20;
  localparam int NSPS_W  = 30;
  localparam int PNS_W   = PER_W + NSPS_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 20;

  localparam logic [NSPS_W-1:0] NANOS_PER_SECOND = NSPS_W'(1000000000);

  localparam logic [CFG_IDX_W-1:0] REG_SYMS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P3   = 3'd4;

  typedef struct packed {
    logic [TS_W-1:0]  start;
    logic [PX_W-1:0]  open;
    logic [PX_W-1:0]  high;
    logic [PX_W-1:0]  low;
    logic [PX_W-1:0]  close;
    logic [VOL_W-1:0] vol;
    logic [CNT_W-1:0] cnt;
  } mfba_ent_t;

endpackage

>>> design/mfba_div.sv
`timescale 1ns / 1ps
module mfba_div
  import mfba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [TS_W-1:0]  dividend,
  input  logic [PNS_W-1:0] divisor,
  output logic             done,
  output logic [PNS_W-1:0] rem
);

  localparam int CW = $clog2(TS_W + 1);

  logic [TS_W-1:0]  q_r, q_nxt;
  logic [PNS_W-1:0] rem_r, rem_nxt;
  logic [PNS_W-1:0] d_r, d_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [PNS_W:0]   trial;

  // one dividend bit per cycle, restoring remainder
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[TS_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(TS_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[TS_W-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = PNS_W'(trial - {1'b0, d_r});
      end else begin
        rem_nxt = trial[PNS_W-1:0];
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> design/multi_timeframe_bar_aggregator_unit.sv
`timescale 1ns / 1ps
// Accepted bar: each timeframe slot steps through multiply, entry read, bit-serial
// alignment remainder plus done, and update, for all four slots in turn. A dropped
// symbol is discarded at the port. One bar in flight; in_stall is high while busy.
// The first result leaves when a later slot closes, else once the last slot is done; results
// wait in a pending register and an output register so the final one carries out_last.
// Synchronous active-low reset clears slot activity and control, restores config defaults.
module multi_timeframe_bar_aggregator_unit
  import mfba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_symbol,
  input  logic [TS_W-1:0]      in_minute_ns,
  input  logic [PX_W-1:0]      in_price_open,
  input  logic [PX_W-1:0]      in_price_high,
  input  logic [PX_W-1:0]      in_price_low,
  input  logic [PX_W-1:0]      in_price_close,
  input  logic [PX_W-1:0]      in_traded_volume,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SYM_W-1:0]     out_symbol,
  output logic [TF_W-1:0]      out_timeframe_slot,
  output logic [TS_W-1:0]      out_bar_start_ns,
  output logic [PX_W-1:0]      out_open,
  output logic [PX_W-1:0]      out_high,
  output logic [PX_W-1:0]      out_low,
  output logic [PX_W-1:0]      out_close,
  output logic [VOL_W-1:0]     out_volume,
  output logic [CNT_W-1:0]     out_bars_done,
  output logic                 out_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam int RES_W = SYM_W + TF_W + $bits(mfba_ent_t);

  // configuration
  logic [6:0]       syms_r;
  logic [PER_W-1:0] per_r [NUM_TF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      syms_r    <= 7'd64;
      per_r[0]  <= PER_W'(300);
      per_r[1]  <= PER_W'(900);
      per_r[2]  <= PER_W'(3600);
      per_r[3]  <= PER_W'(14400);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYMS: syms_r   <= cfg_data[6:0];
        REG_P0:   per_r[0] <= cfg_data;
        REG_P1:   per_r[1] <= cfg_data;
        REG_P2:   per_r[2] <= cfg_data;
        REG_P3:   per_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and item registers
  logic [2:0]       st_r, st_nxt;
  logic [TF_W-1:0]  k_r, k_nxt;
  logic [SYM_W-1:0] sym_r;
  logic [TS_W-1:0]  ts_r;
  logic [PX_W-1:0]  po_r, ph_r, pl_r, pc_r, pv_r;
  logic [PNS_W-1:0] pns_r;
  logic [TS_W:0]    sum_r;
  logic [DEPTH-1:0] act_r;

  // entry store: one read and one write port, registered read
  mfba_ent_t        mem [DEPTH];
  mfba_ent_t        rd_r;
  mfba_ent_t        wd;
  logic [ADDR_W-1:0] addr;
  logic             mem_we;

  assign addr = {sym_r, k_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wd;
    end
    rd_r <= mem[addr];
  end

  // alignment remainder unit
  logic             div_start;
  logic             div_done;
  logic [PNS_W-1:0] rem;

  assign div_start = (st_r == ST_LOAD);

  mfba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ts_r),
    .divisor  (pns_r),
    .done     (div_done),
    .rem      (rem)
  );

  // result buffering: pending beat plus output register
  logic [RES_W-1:0] pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [RES_W-1:0] ob_r, ob_nxt;
  logic             ob_last_r, ob_last_nxt;
  logic             ob_v_r, ob_v_nxt;
  logic             ob_free;

  assign ob_free = !ob_v_r || !out_stall;

  logic             in_acc;
  logic             sym_ok;
  logic [PER_W-1:0] psec;
  logic [TS_W-1:0]  aligned;
  logic             act_e;
  logic             emit;
  logic [VOL_W:0]   vsum;
  logic [TS_W-1:0]  aligned_r;
  logic [RES_W-1:0] res;

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign sym_ok   = (in_symbol < {1'b0, syms_r}) && (in_symbol < 8'(MAX_SYM));
  assign psec     = (per_r[k_r] == '0) ? PER_W'(1) : per_r[k_r];
  assign aligned  = ts_r - {{(TS_W-PNS_W){1'b0}}, rem};
  assign act_e    = act_r[addr];
  assign emit     = act_e && ({1'b0, ts_r} >= sum_r);
  assign vsum     = {1'b0, rd_r.vol} + {{(VOL_W-PX_W+1){1'b0}}, pv_r};

  always_comb begin
    wd = rd_r;
    if (!act_e || emit) begin
      wd.start = aligned_r;
      wd.open  = po_r;
      wd.high  = ph_r;
      wd.low   = pl_r;
      wd.close = pc_r;
      wd.vol   = {{(VOL_W-PX_W){1'b0}}, pv_r};
      wd.cnt   = act_e ? rd_r.cnt + CNT_W'(1) : '0;
    end else begin
      if (ph_r > rd_r.high) wd.high = ph_r;
      if (pl_r < rd_r.low)  wd.low  = pl_r;
      wd.close = pc_r;
      // saturate the running volume
      wd.vol = vsum[VOL_W] ? {VOL_W{1'b1}} : vsum[VOL_W-1:0];
    end
  end

  // finished bar as it stood, with its new count
  always_comb begin
    mfba_ent_t done_ent;
    done_ent     = rd_r;
    done_ent.cnt = rd_r.cnt + CNT_W'(1);
    res          = {sym_r, k_r, done_ent};
  end

  always_comb begin
    st_nxt      = st_r;
    k_nxt       = k_r;
    mem_we      = 1'b0;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    ob_nxt      = ob_r;
    ob_last_nxt = ob_last_r;
    ob_v_nxt    = ob_v_r && out_stall;
    unique case (st_r)
      ST_IDLE: begin
        // drop out-of-range symbols right at the port
        if (in_acc && sym_ok) begin
          st_nxt = ST_MUL;
          k_nxt  = '0;
        end
      end
      ST_MUL:  st_nxt = ST_LOAD;
      ST_LOAD: st_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) st_nxt = ST_UPD;
      end
      ST_UPD: begin
        // hold when a finished bar must push the pending one out and cannot
        if (!(emit && pend_v_r && !ob_free)) begin
          mem_we = 1'b1;
          if (emit) begin
            if (pend_v_r) begin
              ob_nxt      = pend_r;
              ob_last_nxt = 1'b0;
              ob_v_nxt    = 1'b1;
            end
            pend_nxt   = res;
            pend_v_nxt = 1'b1;
          end
          if (k_r == TF_W'(NUM_TF - 1)) begin
            st_nxt = ST_FIN;
          end else begin
            k_nxt  = k_r + TF_W'(1);
            st_nxt = ST_MUL;
          end
        end
      end
      ST_FIN: begin
        if (!pend_v_r) begin
          st_nxt = ST_IDLE;
        end else if (ob_free) begin
          ob_nxt      = pend_r;
          ob_last_nxt = 1'b1;
          ob_v_nxt    = 1'b1;
          pend_v_nxt  = 1'b0;
          st_nxt      = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      k_r      <= '0;
      act_r    <= '0;
      pend_v_r <= 1'b0;
      ob_v_r   <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      k_r      <= k_nxt;
      pend_v_r <= pend_v_nxt;
      ob_v_r   <= ob_v_nxt;
      if (mem_we) act_r[addr] <= 1'b1;
    end
    pend_r    <= pend_nxt;
    ob_r      <= ob_nxt;
    ob_last_r <= ob_last_nxt;
    if (in_acc) begin
      sym_r <= in_symbol[SYM_W-1:0];
      ts_r  <= in_minute_ns;
      po_r  <= in_price_open;
      ph_r  <= in_price_high;
      pl_r  <= in_price_low;
      pc_r  <= in_price_close;
      pv_r  <= in_traded_volume;
    end
    if (st_r == ST_MUL) begin
      pns_r <= {{(PNS_W-PER_W){1'b0}}, psec} * {{PER_W{1'b0}}, NANOS_PER_SECOND};
    end
    sum_r     <= {1'b0, rd_r.start} + {{(TS_W+1-PNS_W){1'b0}}, pns_r};
    aligned_r <= aligned;
  end

  mfba_ent_t ob_ent;
  assign ob_ent = ob_r[$bits(mfba_ent_t)-1:0];

  assign out_valid          = ob_v_r;
  assign out_symbol         = ob_r[RES_W-1 -: SYM_W];
  assign out_timeframe_slot = ob_r[RES_W-SYM_W-1 -: TF_W];
  assign out_bar_start_ns   = ob_ent.start;
  assign out_open           = ob_ent.open;
  assign out_high           = ob_ent.high;
  assign out_low            = ob_ent.low;
  assign out_close          = ob_ent.close;
  assign out_volume         = ob_ent.vol;
  assign out_bars_done      = ob_ent.cnt;
  assign out_last           = ob_last_r;

endmodule

>>> tb/sv/multi_timeframe_bar_aggregator_unit_test.sv
`timescale 1ns / 1ps
module multi_timeframe_bar_aggregator_unit_test
  import mfba_pkg::*;
;

  localparam longint unsigned MINUTE_NS = 64'd60000000000;
  localparam longint unsigned SEC_NS    = 64'd1000000000;
  localparam longint unsigned VOL_MAX   = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned TS_MASK   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int              SETTLE    = 400;
  localparam int              HOLD_LONG = 1500;
  localparam longint          CYCLE_CAP = 600000;

  typedef struct packed {
    logic [7:0]      sym;
    logic [TS_W-1:0] ts;
    logic [PX_W-1:0] po;
    logic [PX_W-1:0] ph;
    logic [PX_W-1:0] pl;
    logic [PX_W-1:0] pc;
    logic [PX_W-1:0] pv;
  } minute_bar_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [TF_W-1:0]  tf;
    logic [TS_W-1:0]  start;
    logic [PX_W-1:0]  po;
    logic [PX_W-1:0]  ph;
    logic [PX_W-1:0]  pl;
    logic [PX_W-1:0]  pc;
    logic [VOL_W-1:0] vol;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } done_bar_t;

  // directed row: the bar plus a flag for rows that must complete nothing
  typedef struct packed {
    minute_bar_t bar;
    logic        quiet_row;
  } minute_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [7:0] in_symbol;
  logic [TS_W-1:0] in_minute_ns;
  logic [PX_W-1:0] in_price_open, in_price_high, in_price_low, in_price_close;
  logic [PX_W-1:0] in_traded_volume;
  logic out_valid, out_stall;
  logic [SYM_W-1:0] out_symbol;
  logic [TF_W-1:0] out_timeframe_slot;
  logic [TS_W-1:0] out_bar_start_ns;
  logic [PX_W-1:0] out_open, out_high, out_low, out_close;
  logic [VOL_W-1:0] out_volume;
  logic [CNT_W-1:0] out_bars_done;
  logic out_last;

  multi_timeframe_bar_aggregator_unit dut (.*);

  // shadow configuration and running-bar store
  logic [6:0]        syms_cfg;
  logic [PER_W-1:0]  period_cfg [NUM_TF];
  logic              run_live  [DEPTH];
  logic [TS_W-1:0]   run_start [DEPTH];
  logic [PX_W-1:0]   run_o [DEPTH], run_h [DEPTH], run_l [DEPTH], run_c [DEPTH];
  logic [VOL_W-1:0]  run_vol [DEPTH];
  logic [CNT_W-1:0]  run_cnt [DEPTH];

  done_bar_t         finished_bars [$];
  longint unsigned   minute_clock [256];
  int                bar_errors = 0;
  int                shown = 0;
  bit                no_idle = 0;
  bit                hold_req = 0;
  longint            cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("FAIL multi_timeframe_bar_aggregator_unit");
      $finish;
    end
  end

  // Fold one accepted minute bar into the shadow store; queue every bar it closes.
  function automatic int fold_minute(minute_bar_t b);
    int lim, e, n;
    longint unsigned pns, ts, aligned, v;
    done_bar_t r;
    lim = (syms_cfg > MAX_SYM) ? MAX_SYM : int'(syms_cfg);
    if (int'(b.sym) >= lim) return 0;
    n = 0;
    ts = longint'(b.ts);
    for (int k = 0; k < NUM_TF; k++) begin
      e = int'(b.sym) * NUM_TF + k;
      // zero period behaves as one second
      pns = ((period_cfg[k] == 0) ? 64'd1 : longint'(period_cfg[k])) * SEC_NS;
      aligned = (ts / pns) * pns;
      if (run_live[e] && ts >= longint'(run_start[e]) + pns) begin
        run_cnt[e] = run_cnt[e] + 1;
        r.sym = b.sym[SYM_W-1:0];
        r.tf = k[TF_W-1:0];
        r.start = run_start[e];
        r.po = run_o[e];
        r.ph = run_h[e];
        r.pl = run_l[e];
        r.pc = run_c[e];
        r.vol = run_vol[e];
        r.cnt = run_cnt[e];
        r.last = 1'b0;
        finished_bars.push_back(r);
        n++;
      end
      if (!run_live[e] || ts >= longint'(run_start[e]) + pns) begin
        run_live[e] = 1'b1;
        run_start[e] = aligned[TS_W-1:0];
        run_o[e] = b.po;
        run_h[e] = b.ph;
        run_l[e] = b.pl;
        run_c[e] = b.pc;
        run_vol[e] = VOL_W'(b.pv);
      end else begin
        // accumulate, also for timestamps that go backwards
        if (b.ph > run_h[e]) run_h[e] = b.ph;
        if (b.pl < run_l[e]) run_l[e] = b.pl;
        run_c[e] = b.pc;
        v = longint'(run_vol[e]) + longint'(b.pv);
        run_vol[e] = (v > VOL_MAX) ? VOL_W'(VOL_MAX) : v[VOL_W-1:0];
      end
    end
    if (n > 0) finished_bars[finished_bars.size()-1].last = 1'b1;
    return n;
  endfunction

  // Present one beat and hold it until the block takes it.
  task automatic offer_minute(minute_bar_t b, output int produced);
    in_valid <= 1'b1;
    in_symbol <= b.sym;
    in_minute_ns <= b.ts;
    in_price_open <= b.po;
    in_price_high <= b.ph;
    in_price_low <= b.pl;
    in_price_close <= b.pc;
    in_traded_volume <= b.pv;
    do @(posedge clk); while (in_stall);
    produced = fold_minute(b);
  endtask

  // Drop valid for a random burst now and then.
  task automatic maybe_gap();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Wait until every expected bar is out, then let the block go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (finished_bars.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [6:0] syms, logic [PER_W-1:0] p0, logic [PER_W-1:0] p1,
                           logic [PER_W-1:0] p2, logic [PER_W-1:0] p3);
    logic [CFG_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0] idx [5];
    vals = '{CFG_W'(syms), p0, p1, p2, p3};
    idx = '{REG_SYMS, REG_P0, REG_P1, REG_P2, REG_P3};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    syms_cfg = syms;
    period_cfg = '{p0, p1, p2, p3};
  endtask

  // Mostly orderly minute streams on a few symbols, with jumps, rewinds and strays.
  function automatic minute_bar_t make_minute(int lim);
    minute_bar_t b;
    int pick, span;
    span = (lim > 8) ? 8 : lim;
    if (span == 0 || $urandom_range(0, 9) == 0) b.sym = 8'($urandom_range(0, 255));
    else b.sym = 8'($urandom_range(0, span - 1));
    pick = $urandom_range(0, 19);
    if (pick == 0)
      minute_clock[b.sym] = {$urandom, $urandom} & TS_MASK;
    else if (pick == 1 && minute_clock[b.sym] >= MINUTE_NS)
      minute_clock[b.sym] -= MINUTE_NS;
    else
      minute_clock[b.sym] = (minute_clock[b.sym] + MINUTE_NS * $urandom_range(1, 4)) & TS_MASK;
    b.ts = minute_clock[b.sym][TS_W-1:0];
    b.po = $urandom;
    b.ph = $urandom;
    b.pl = $urandom;
    b.pc = $urandom;
    b.pv = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
    return b;
  endfunction

  task automatic random_run(int count, int lim, int hold_at);
    minute_bar_t b;
    int produced;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1;
      b = make_minute(lim);
      offer_minute(b, produced);
      maybe_gap();
    end
  endtask

  // receiver: random stall bursts, one long hold-off on request, none at the end
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (HOLD_LONG) @(posedge clk);
      end else if (no_idle) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20)) @(posedge clk);
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // check every bar beat against the oldest expectation
  always @(posedge clk) begin
    done_bar_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_symbol, out_timeframe_slot, out_bar_start_ns, out_open, out_high,
              out_low, out_close, out_volume, out_bars_done, out_last};
      if (finished_bars.size() == 0) begin
        bar_errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected bar beat: sym %0d slot %0d start %0d", got.sym, got.tf,
                   got.start);
        end
      end else begin
        want = finished_bars.pop_front();
        if (got !== want) begin
          bar_errors++;
          if (shown < 10) begin
            shown++;
            $display("bar mismatch exp sym %0d tf %0d st %0d o %h h %h l %h c %h v %h n %0d l %b",
                     want.sym, want.tf, want.start, want.po, want.ph, want.pl, want.pc,
                     want.vol, want.cnt, want.last);
            $display("             got sym %0d tf %0d st %0d o %h h %h l %h c %h v %h n %0d l %b",
                     got.sym, got.tf, got.start, got.po, got.ph, got.pl, got.pc,
                     got.vol, got.cnt, got.last);
          end
        end
      end
    end
  end

  minute_row_t directed [13];

  initial begin
    int produced;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SYMS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_symbol = '0;
    in_minute_ns = '0;
    in_price_open = '0;
    in_price_high = '0;
    in_price_low = '0;
    in_price_close = '0;
    in_traded_volume = '0;
    syms_cfg = 7'd64;
    period_cfg = '{20'd300, 20'd900, 20'd3600, 20'd14400};
    for (int i = 0; i < DEPTH; i++) begin
      run_live[i] = 0; run_start[i] = '0; run_o[i] = '0; run_h[i] = '0;
      run_l[i] = '0; run_c[i] = '0; run_vol[i] = '0; run_cnt[i] = '0;
    end
    foreach (minute_clock[i]) minute_clock[i] = 0;

    // reset periods 300 / 900 / 3600 / 14400 s, all 64 symbols live
    directed = '{
      // first bars open every slot, extremes of price and volume
      '{'{8'd0, 63'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1},
      '{'{8'd0, 63'd60000000000, 32'd5, 32'd1, 32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFF}, 1'b1},
      // five minutes in: slot 0 closes
      '{'{8'd0, 63'd300000000000, 32'd11, 32'd40, 32'd9, 32'd20, 32'd7}, 1'b0},
      // timestamp going backwards accumulates
      '{'{8'd0, 63'd120000000000, 32'd12, 32'd50, 32'd2, 32'd21, 32'd8}, 1'b1},
      '{'{8'd63, 63'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1},
      // symbols beyond the store are dropped
      '{'{8'd64, 63'd0, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1}, 1'b1},
      '{'{8'd255, 63'h7FFF_FFFF_FFFF_FFFF, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1}, 1'b1},
      '{'{8'd128, 63'd0, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1}, 1'b1},
      // latest timestamp closes all four slots at once
      '{'{8'd63, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0},
      '{'{8'd0, 63'd1200000000000, 32'd1, 32'd2, 32'd0, 32'd1, 32'd3}, 1'b0},
      '{'{8'd1, 63'd55, 32'd100, 32'd110, 32'd90, 32'd105, 32'd1000}, 1'b1},
      '{'{8'd1, 63'd3600000000000, 32'd101, 32'd111, 32'd91, 32'd104, 32'd999}, 1'b0},
      '{'{8'd0, 63'd14400000000000, 32'd2, 32'd3, 32'd1, 32'd2, 32'd4}, 1'b0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      offer_minute(directed[i].bar, produced);
      if (directed[i].quiet_row && produced != 0) begin
        bar_errors++;
        if (shown < 10) begin
          shown++;
          $display("directed row %0d should close no bar: exp 0 got %0d", i, produced);
        end
      end
      maybe_gap();
    end
    drain();

    // no symbols in use: everything dropped; zero periods act as one second
    write_cfg(7'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    random_run(5, 0, -1);
    drain();

    // oversized symbol count clamps to the store; mixed period extremes
    write_cfg(7'd127, 20'd0, 20'd1, 20'd604800, 20'd60);
    random_run(30, 64, -1);
    drain();

    // receiver holds off for a long stretch so the input backs up
    write_cfg(7'($urandom_range(1, 64)), 20'($urandom_range(60, 900)),
              20'($urandom_range(60, 900)), 20'($urandom_range(60, 900)),
              20'($urandom_range(60, 900)));
    random_run(40, int'(syms_cfg), 5);
    drain();

    write_cfg(7'd64, 20'd604800, 20'd604800, 20'd604800, 20'hFFFFF);
    random_run(20, 64, -1);
    drain();

    // closing stretch with no idling on either side
    write_cfg(7'($urandom_range(1, 64)), 20'($urandom_range(60, 300)),
              20'($urandom_range(60, 300)), 20'($urandom_range(120, 600)),
              20'($urandom_range(120, 900)));
    no_idle = 1;
    random_run(35, int'(syms_cfg), -1);
    drain();

    if (bar_errors == 0 && finished_bars.size() == 0) begin
      $display("PASS multi_timeframe_bar_aggregator_unit");
    end else begin
      $display("FAIL multi_timeframe_bar_aggregator_unit");
    end
    $finish;
  end

endmodule
